### sv/slpc_pkg.sv
// Package for the spectral light-pollution classifier.
// Holds the code constants, register indexes, reset values and pipeline stage types.
// No dependencies; the classifier top imports it.
package slpc_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_LED_THR = 2'd0;
  localparam logic [1:0] REG_NA_THR  = 2'd1;
  localparam logic [1:0] REG_LED_MAX = 2'd2;
  localparam logic [1:0] REG_NA_MAX  = 2'd3;

  // Register reset values.
  localparam logic [15:0] RST_LED_THR = 16'd128;
  localparam logic [15:0] RST_NA_THR  = 16'd307;
  localparam logic [15:0] RST_LED_MAX = 16'd1229;
  localparam logic [15:0] RST_NA_MAX  = 16'd2048;

  // Light source classes.
  localparam logic [2:0] SRC_NATURAL = 3'd0;
  localparam logic [2:0] SRC_LED     = 3'd1;
  localparam logic [2:0] SRC_SODIUM  = 3'd2;
  localparam logic [2:0] SRC_MERCURY = 3'd3;
  localparam logic [2:0] SRC_MIXED   = 3'd4;

  // Sky verdicts.
  localparam logic [2:0] SKY_NO_DATA  = 3'd0;
  localparam logic [2:0] SKY_HAZE     = 3'd1;
  localparam logic [2:0] SKY_OVERCAST = 3'd2;
  localparam logic [2:0] SKY_MOSTLY   = 3'd3;
  localparam logic [2:0] SKY_PARTLY   = 3'd4;
  localparam logic [2:0] SKY_CLEAR    = 3'd5;

  // Solar photography verdicts.
  localparam logic [1:0] SOLAR_EXCELLENT = 2'd0;
  localparam logic [1:0] SOLAR_GOOD      = 2'd1;
  localparam logic [1:0] SOLAR_MEDIOCRE  = 2'd2;
  localparam logic [1:0] SOLAR_POOR      = 2'd3;

  // Mercury correction, 0.15 in Q4.12 floored.
  localparam logic [15:0] HG_CORR = 16'd614;

  // Pipeline geometry: six front stages, sixteen divider stages, one output stage.
  localparam int unsigned FRONT_STAGES = 6;
  localparam int unsigned DIV_STAGES   = 16;
  localparam int unsigned NUM_STAGES   = FRONT_STAGES + DIV_STAGES + 1;
  localparam int unsigned QUAL_STEPS   = 7;

  // Widths of the arithmetic.
  localparam int unsigned CNUM_W = 40;  // correction dividend
  localparam int unsigned CDEN_W = 32;  // correction divisor
  localparam int unsigned QNUM_W = 46;  // quality dividend
  localparam int unsigned QDEN_W = 38;  // quality divisor
  localparam int unsigned LNUM_W = 25;  // clarity dividend
  localparam int unsigned LDEN_W = 19;  // clarity divisor

  // Control carried through the whole pipeline.
  typedef struct packed {
    logic        gz;
    logic [2:0]  src;
    logic        need_div;
    logic [15:0] corr_fixed;
    logic [15:0] cap;
    logic [2:0]  sky;
    logic        nir_low;
    logic        cpos;
  } ctl_t;

  // Stage A: products, sums and near infrared flags.
  typedef struct packed {
    logic [7:0][15:0] ch;
    logic [31:0]      den_l;
    logic [31:0]      den_n;
    logic [18:0]      s;
    logic [17:0]      b;
    logic [16:0]      r;
    logic             nir_high;
    logic             nir_low;
  } sa_t;

  // Stage B: classification, deviations, sky code, clarity operands.
  typedef struct packed {
    ctl_t             ctl;
    logic [31:0]      den;
    logic [23:0]      diff;
    logic [7:0][18:0] d;
    logic [18:0]      s;
    logic [24:0]      cnum;
    logic [18:0]      cden;
  } sb_t;

  // Stage C: products.
  typedef struct packed {
    ctl_t             ctl;
    logic             csat;
    logic [31:0]      den;
    logic [39:0]      num;
    logic [47:0]      capden;
    logic [7:0][37:0] sq;
    logic [37:0]      s2;
    logic [24:0]      cnum;
    logic [18:0]      cden;
  } sc_t;

  // Stages D and E: correction saturation and the sum-of-squares tree.
  typedef struct packed {
    ctl_t             ctl;
    logic             csat;
    logic             corr_sat;
    logic [31:0]      den;
    logic [39:0]      num;
    logic [3:0][38:0] pair;
    logic [37:0]      s2;
    logic [24:0]      cnum;
    logic [18:0]      cden;
  } sd_t;

  typedef struct packed {
    ctl_t        ctl;
    logic        csat;
    logic        corr_sat;
    logic [31:0] den;
    logic [39:0] num;
    logic [40:0] q;
    logic [37:0] s2;
    logic [24:0] cnum;
    logic [18:0] cden;
  } se_t;

  // Stage F and the divider stages.
  typedef struct packed {
    ctl_t        ctl;
    logic        csat;
    logic        corr_sat;
    logic        qsat;
    logic [39:0] crem;
    logic [31:0] cdiv;
    logic [15:0] cq;
    logic [45:0] qrem;
    logic [37:0] s2;
    logic [6:0]  qq;
    logic [24:0] lrem;
    logic [18:0] ldiv;
    logic [6:0]  lq;
  } dv_t;

  // Output register.
  typedef struct packed {
    logic [2:0]  src;
    logic [15:0] corr;
    logic [6:0]  qual;
    logic [6:0]  clar;
    logic [2:0]  sky;
    logic [1:0]  solar;
  } so_t;

endpackage

### sv/slpc_div_step.sv
// One restoring division step of the classifier's pipelined dividers.
// Compares the partial remainder with the divisor shifted by SHIFT and subtracts.
// Depends on nothing outside this file.
module slpc_div_step #(
  parameter int unsigned NUM_W = 40,
  parameter int unsigned DEN_W = 32,
  parameter int unsigned SHIFT = 0
) (
  input  logic [NUM_W-1:0] rem_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] rem_o,
  output logic             bit_o
);

  localparam int unsigned W = ((NUM_W > DEN_W + SHIFT) ? NUM_W : DEN_W + SHIFT) + 1;

  logic [W-1:0] rem_ext;
  logic [W-1:0] sub_ext;
  logic [W-1:0] dif_ext;

  // Trial subtraction of the shifted divisor.
  assign rem_ext = W'(rem_i);
  assign sub_ext = W'(den_i) << SHIFT;
  assign dif_ext = rem_ext - sub_ext;
  assign bit_o   = (rem_ext >= sub_ext);
  assign rem_o   = bit_o ? dif_ext[NUM_W-1:0] : rem_i;

endmodule

### sv/spectral_light_pollution_classifier.sv
// Spectral light-pollution classifier: one result item for every ten-channel
// reading, through a 23-stage pipeline. A new item can be taken in every cycle
// while the output side does not stall; a stalled pipeline holds in_ready low
// once it has no bubble left. Six front stages do the ratio tests, products and the
// sum of squares; sixteen stages then run the restoring dividers one quotient
// bit per stage (sixteen bits for the correction, seven for the quality and
// clarity scores); the last stage is the output register. Each stage holds its
// item when the stage after it is full and stalled, so bubbles are filled while
// the output waits. Configuration registers must be written through the cfg port
// with the pipeline empty, which the block does not enforce; cfg_ready is always high.
// Depends on slpc_pkg and slpc_div_step.
module spectral_light_pollution_classifier (
  input  logic        clk,
  input  logic        rst_n,
  // configuration port
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_violet_415,
  input  logic [15:0] in_indigo_445,
  input  logic [15:0] in_blue_480,
  input  logic [15:0] in_cyan_515,
  input  logic [15:0] in_green_555,
  input  logic [15:0] in_yellow_590,
  input  logic [15:0] in_orange_630,
  input  logic [15:0] in_red_680,
  input  logic [15:0] in_broadband_clear,
  input  logic [15:0] in_near_infrared,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_source_class,
  output logic [15:0] out_brightness_correction,
  output logic [6:0]  out_quality_index,
  output logic [6:0]  out_clarity_percent,
  output logic [2:0]  out_sky_code,
  output logic [1:0]  out_solar_code
);

  import slpc_pkg::*;

  localparam int unsigned IX_A = 0;
  localparam int unsigned IX_F = FRONT_STAGES - 1;
  localparam int unsigned IX_O = NUM_STAGES - 1;

  // Configuration registers.
  logic [15:0] led_thr_r, na_thr_r, led_max_r, na_max_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_thr_r <= RST_LED_THR;
      na_thr_r  <= RST_NA_THR;
      led_max_r <= RST_LED_MAX;
      na_max_r  <= RST_NA_MAX;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LED_THR: led_thr_r <= cfg_data;
        REG_NA_THR:  na_thr_r  <= cfg_data;
        REG_LED_MAX: led_max_r <= cfg_data;
        REG_NA_MAX:  na_max_r  <= cfg_data;
        default:     led_thr_r <= led_thr_r;
      endcase
    end
  end

  // Stage valid bits and the per-stage load enables.
  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES:0]   en;

  always_comb begin
    en[NUM_STAGES] = out_ready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[IX_O];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Stage A: green-scaled thresholds, channel sums and the near infrared flags.
  sa_t a_r, a_nxt;

  always_comb begin
    a_nxt.ch       = {in_red_680, in_orange_630, in_yellow_590, in_green_555,
                      in_cyan_515, in_blue_480, in_indigo_445, in_violet_415};
    a_nxt.den_l    = 32'(led_thr_r) * 32'(in_green_555);
    a_nxt.den_n    = 32'(na_thr_r) * 32'(in_green_555);
    a_nxt.s        = 19'(in_violet_415) + 19'(in_indigo_445) + 19'(in_blue_480)
                   + 19'(in_cyan_515) + 19'(in_green_555) + 19'(in_yellow_590)
                   + 19'(in_orange_630) + 19'(in_red_680);
    a_nxt.b        = 18'(in_violet_415) + 18'(in_indigo_445) + 18'(in_blue_480);
    a_nxt.r        = 17'(in_orange_630) + 17'(in_red_680);
    a_nxt.nir_high = (in_broadband_clear != '0)
                   && (19'(in_near_infrared) * 19'd5 > 19'(in_broadband_clear) * 19'd3);
    a_nxt.nir_low  = (in_broadband_clear == '0)
                   || (19'(in_near_infrared) * 19'd5 < 19'(in_broadband_clear) * 19'd2);
  end

  always_ff @(posedge clk) begin
    if (en[IX_A]) a_r <= a_nxt;
  end

  // Stage B: source class, deviations from the mean, sky code, clarity operands.
  sb_t b_r, b_nxt;

  logic [15:0] g_a, cy1_a;
  logic        is_led, is_na, is_hg;
  logic [16:0] max_sum;
  logic [20:0] b5, r4, r6, r9, b2, r5;
  logic [18:0] b2_19;

  always_comb begin
    g_a    = a_r.ch[4];
    cy1_a  = (a_r.ch[3] != '0) ? a_r.ch[3] : 16'd1;
    is_led = {8'd0, a_r.ch[1], 8'd0} > a_r.den_l;
    is_na  = {8'd0, a_r.ch[5], 8'd0} > a_r.den_n;
    is_hg  = (19'(a_r.ch[0]) * 19'd5 > 19'(g_a) * 19'd4)
          && (19'(a_r.ch[1]) * 19'd5 > 19'(g_a) * 19'd3)
          && (20'(g_a) * 20'd10 > 20'(cy1_a) * 20'd13);
    max_sum = 17'(led_max_r) + 17'(na_max_r);

    b_nxt = '0;
    b_nxt.ctl.gz      = (g_a == '0);
    b_nxt.ctl.nir_low = a_r.nir_low;
    b_nxt.s           = a_r.s;

    // Classification in order of precedence; zero green leaves it natural.
    priority if (g_a == '0) begin
      b_nxt.ctl.src = SRC_NATURAL;
    end else if (is_hg) begin
      b_nxt.ctl.src        = SRC_MERCURY;
      b_nxt.ctl.corr_fixed = HG_CORR;
    end else if (is_led && is_na) begin
      b_nxt.ctl.src        = SRC_MIXED;
      b_nxt.ctl.corr_fixed = max_sum[16:1];
    end else if (is_led) begin
      b_nxt.ctl.src      = SRC_LED;
      b_nxt.ctl.need_div = 1'b1;
      b_nxt.ctl.cap      = led_max_r;
      b_nxt.den          = a_r.den_l;
      b_nxt.diff         = {a_r.ch[1], 8'd0} - a_r.den_l[23:0];
    end else if (is_na) begin
      b_nxt.ctl.src      = SRC_SODIUM;
      b_nxt.ctl.need_div = 1'b1;
      b_nxt.ctl.cap      = na_max_r;
      b_nxt.den          = a_r.den_n;
      b_nxt.diff         = {a_r.ch[5], 8'd0} - a_r.den_n[23:0];
    end else begin
      b_nxt.ctl.src = SRC_NATURAL;
    end

    // Distance of each narrow channel from the mean, scaled by eight.
    for (int i = 0; i < 8; i++) begin
      b_nxt.d[i] = ({a_r.ch[i], 3'd0} > a_r.s) ? {a_r.ch[i], 3'd0} - a_r.s
                                                : a_r.s - {a_r.ch[i], 3'd0};
    end

    // Sky verdict from the blue/red ratio and the near infrared flag.
    b5 = 21'(a_r.b) * 21'd5;
    r4 = 21'(a_r.r) * 21'd4;
    r6 = 21'(a_r.r) * 21'd6;
    r9 = 21'(a_r.r) * 21'd9;
    b2 = 21'(a_r.b) * 21'd2;
    r5 = 21'(a_r.r) * 21'd5;
    priority if (a_r.r == '0)              b_nxt.ctl.sky = SKY_NO_DATA;
    else if (b5 < r4 || a_r.nir_high)      b_nxt.ctl.sky = SKY_HAZE;
    else if (b5 < r6)                      b_nxt.ctl.sky = SKY_OVERCAST;
    else if (b5 < r9)                      b_nxt.ctl.sky = SKY_MOSTLY;
    else if (b2 < r5)                      b_nxt.ctl.sky = SKY_PARTLY;
    else                                   b_nxt.ctl.sky = SKY_CLEAR;

    // Clarity operands: 50 * (2B - R) over 3R.
    b2_19          = {a_r.b, 1'b0};
    b_nxt.ctl.cpos = (a_r.r != '0) && (b2_19 > 19'(a_r.r));
    b_nxt.cnum     = 25'(b2_19 - 19'(a_r.r)) * 25'd50;
    b_nxt.cden     = 19'(a_r.r) * 19'd3;
  end

  always_ff @(posedge clk) begin
    if (en[IX_A+1]) b_r <= b_nxt;
  end

  // Stage C: correction products, squares and clarity saturation.
  sc_t c_r, c_nxt;

  always_comb begin
    c_nxt.ctl    = b_r.ctl;
    c_nxt.den    = b_r.den;
    c_nxt.num    = 40'(b_r.diff) * 40'(b_r.ctl.cap);
    c_nxt.capden = 48'(b_r.ctl.cap) * 48'(b_r.den);
    for (int i = 0; i < 8; i++) begin
      c_nxt.sq[i] = 38'(b_r.d[i]) * 38'(b_r.d[i]);
    end
    c_nxt.s2   = 38'(b_r.s) * 38'(b_r.s);
    c_nxt.csat = {1'b0, b_r.cnum} >= {b_r.cden, 7'd0};
    c_nxt.cnum = b_r.cnum;
    c_nxt.cden = b_r.cden;
  end

  always_ff @(posedge clk) begin
    if (en[IX_A+2]) c_r <= c_nxt;
  end

  // Stage D: correction saturation and first level of the square sum.
  sd_t d_r, d_nxt;

  always_comb begin
    d_nxt.ctl      = c_r.ctl;
    d_nxt.csat     = c_r.csat;
    d_nxt.corr_sat = (c_r.den == '0) || ({8'd0, c_r.num} >= c_r.capden);
    d_nxt.den      = c_r.den;
    d_nxt.num      = c_r.num;
    for (int i = 0; i < 4; i++) begin
      d_nxt.pair[i] = 39'(c_r.sq[2*i]) + 39'(c_r.sq[2*i+1]);
    end
    d_nxt.s2   = c_r.s2;
    d_nxt.cnum = c_r.cnum;
    d_nxt.cden = c_r.cden;
  end

  always_ff @(posedge clk) begin
    if (en[IX_A+3]) d_r <= d_nxt;
  end

  // Stage E: rest of the square sum.
  se_t e_r, e_nxt;

  always_comb begin
    e_nxt.ctl      = d_r.ctl;
    e_nxt.csat     = d_r.csat;
    e_nxt.corr_sat = d_r.corr_sat;
    e_nxt.den      = d_r.den;
    e_nxt.num      = d_r.num;
    e_nxt.q        = 41'(d_r.pair[0]) + 41'(d_r.pair[1])
                   + 41'(d_r.pair[2]) + 41'(d_r.pair[3]);
    e_nxt.s2       = d_r.s2;
    e_nxt.cnum     = d_r.cnum;
    e_nxt.cden     = d_r.cden;
  end

  always_ff @(posedge clk) begin
    if (en[IX_A+4]) e_r <= e_nxt;
  end

  // Stage F: quality dividend 25q, its saturation, and divider set-up.
  dv_t f_r, f_nxt;

  always_comb begin
    f_nxt.ctl      = e_r.ctl;
    f_nxt.csat     = e_r.csat;
    f_nxt.corr_sat = e_r.corr_sat;
    f_nxt.qsat     = e_r.q >= {1'b0, e_r.s2, 2'd0};
    f_nxt.crem     = e_r.num;
    f_nxt.cdiv     = e_r.den;
    f_nxt.cq       = '0;
    f_nxt.qrem     = (46'(e_r.q) << 4) + (46'(e_r.q) << 3) + 46'(e_r.q);
    f_nxt.s2       = e_r.s2;
    f_nxt.qq       = '0;
    f_nxt.lrem     = e_r.cnum;
    f_nxt.ldiv     = e_r.cden;
    f_nxt.lq       = '0;
  end

  always_ff @(posedge clk) begin
    if (en[IX_F]) f_r <= f_nxt;
  end

  // Divider stages: one quotient bit per stage, most significant first.
  dv_t dv_r   [DIV_STAGES];
  dv_t dv_in  [DIV_STAGES];
  dv_t dv_nxt [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    localparam int unsigned SH = DIV_STAGES - 1 - k;

    logic [CNUM_W-1:0] crem_o;
    logic              cbit;

    if (k == 0) begin : g_first
      assign dv_in[k] = f_r;
    end else begin : g_next
      assign dv_in[k] = dv_r[k-1];
    end

    slpc_div_step #(.NUM_W(CNUM_W), .DEN_W(CDEN_W), .SHIFT(SH)) u_corr (
      .rem_i (dv_in[k].crem),
      .den_i (dv_in[k].cdiv),
      .rem_o (crem_o),
      .bit_o (cbit)
    );

    if (k >= DIV_STAGES - QUAL_STEPS) begin : g_small
      logic [QNUM_W-1:0] qrem_o;
      logic              qbit;
      logic [LNUM_W-1:0] lrem_o;
      logic              lbit;

      slpc_div_step #(.NUM_W(QNUM_W), .DEN_W(QDEN_W), .SHIFT(SH)) u_qual (
        .rem_i (dv_in[k].qrem),
        .den_i (dv_in[k].s2),
        .rem_o (qrem_o),
        .bit_o (qbit)
      );

      slpc_div_step #(.NUM_W(LNUM_W), .DEN_W(LDEN_W), .SHIFT(SH)) u_clar (
        .rem_i (dv_in[k].lrem),
        .den_i (dv_in[k].ldiv),
        .rem_o (lrem_o),
        .bit_o (lbit)
      );

      always_comb begin
        dv_nxt[k]      = dv_in[k];
        dv_nxt[k].crem = crem_o;
        dv_nxt[k].cq   = {dv_in[k].cq[14:0], cbit};
        dv_nxt[k].qrem = qrem_o;
        dv_nxt[k].qq   = {dv_in[k].qq[5:0], qbit};
        dv_nxt[k].lrem = lrem_o;
        dv_nxt[k].lq   = {dv_in[k].lq[5:0], lbit};
      end
    end else begin : g_wide
      always_comb begin
        dv_nxt[k]      = dv_in[k];
        dv_nxt[k].crem = crem_o;
        dv_nxt[k].cq   = {dv_in[k].cq[14:0], cbit};
      end
    end

    always_ff @(posedge clk) begin
      if (en[FRONT_STAGES + k]) dv_r[k] <= dv_nxt[k];
    end
  end

  // Output stage: final selection, clamps and the solar verdict.
  so_t o_r, o_nxt;
  dv_t dl;
  logic [6:0] qceil;
  logic [6:0] clar;

  always_comb begin
    dl    = dv_r[DIV_STAGES-1];
    qceil = dl.qq + 7'(dl.qrem != '0);

    priority if (!dl.ctl.cpos) clar = 7'd0;
    else if (dl.csat)          clar = 7'd100;
    else if (dl.lq > 7'd100)   clar = 7'd100;
    else                       clar = dl.lq;

    o_nxt.src  = dl.ctl.src;
    o_nxt.clar = clar;
    o_nxt.sky  = dl.ctl.sky;

    priority if (dl.ctl.gz)     o_nxt.corr = '0;
    else if (!dl.ctl.need_div)  o_nxt.corr = dl.ctl.corr_fixed;
    else if (dl.corr_sat)       o_nxt.corr = dl.ctl.cap;
    else                        o_nxt.corr = dl.cq;

    priority if (dl.ctl.gz || dl.qsat) o_nxt.qual = '0;
    else                               o_nxt.qual = 7'd100 - qceil;

    priority if (clar >= 7'd70 && dl.ctl.nir_low) o_nxt.solar = SOLAR_EXCELLENT;
    else if (clar >= 7'd50)                       o_nxt.solar = SOLAR_GOOD;
    else if (clar >= 7'd30)                       o_nxt.solar = SOLAR_MEDIOCRE;
    else                                          o_nxt.solar = SOLAR_POOR;
  end

  always_ff @(posedge clk) begin
    if (en[IX_O]) o_r <= o_nxt;
  end

  assign out_source_class          = o_r.src;
  assign out_brightness_correction = o_r.corr;
  assign out_quality_index         = o_r.qual;
  assign out_clarity_percent       = o_r.clar;
  assign out_sky_code              = o_r.sky;
  assign out_solar_code            = o_r.solar;

  // A natural source never carries a correction.
  a_natural_no_corr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_source_class == SRC_NATURAL) |-> out_brightness_correction == '0)
    else $error("natural source with nonzero correction");

  // A mercury item always carries the fixed mercury correction.
  a_mercury_corr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_source_class == SRC_MERCURY) |-> out_brightness_correction == HG_CORR)
    else $error("mercury correction wrong");

  // Scores stay within 0..100.
  a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_quality_index <= 7'd100) && (out_clarity_percent <= 7'd100))
    else $error("score out of range");

  // No red light means no clarity and a poor solar verdict.
  a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_sky_code == SKY_NO_DATA)
      |-> (out_clarity_percent == '0) && (out_solar_code == SOLAR_POOR))
    else $error("no-data item with clarity");

  // The output stage, when full and not released, keeps its item.
  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(o_r))
    else $error("output stage lost an item");

endmodule
